/* rtl/binary_to_decimal_ascii_top_defines.svh */
// Assertion macros used by the checker file of the decimal text converter.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef BINARY_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define BDA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define BDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bda_pkg.sv */
// Constants shared by the binary to decimal ASCII converter.
// No dependencies.
package bda_pkg;

  localparam int VALUE_W    = 32;
  localparam int DIGIT_W    = 4;
  localparam int CHAR_W     = 6;
  // Decimal digits a 32-bit unsigned value can need.
  localparam int MAX_DIGITS = 10;

  // floor(v / 10) == (v * RECIP_MULT) >> RECIP_SHIFT for every 32-bit v.
  localparam logic [VALUE_W-1:0] RECIP_MULT  = 32'hCCCC_CCCD;
  localparam int                 RECIP_SHIFT = 35;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

endpackage

/* rtl/binary_to_decimal_ascii_top.sv */
// A number goes from the input holding register, which takes a new number while the
// converter works, to the divide-by-ten converter. That yields Steps digits, where Steps
// is NUM_DIGITS limited to the range 1 to 10, at one per cycle unless the full queue stalls
// the last; characters then leave at one per cycle while digits wait and pop is held.
// Reset clears all control state at once; there is no clearing pass.
// Top level: joins the front converter, the digit queue and the character emitter.
// Depends on bda_pkg, bda_front, bda_fifo and bda_back.
module binary_to_decimal_ascii_top #(
  parameter int NUM_DIGITS = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [bda_pkg::VALUE_W-1:0] value_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [bda_pkg::CHAR_W-1:0]  digit_char_o,
  output logic                        last_digit_o
);

  // Digits beyond the tenth are always zero for a 32-bit value.
  localparam int Steps = (NUM_DIGITS < 1) ? 1 :
                         ((NUM_DIGITS > bda_pkg::MAX_DIGITS) ? bda_pkg::MAX_DIGITS
                                                             : NUM_DIGITS);
  localparam int DigW  = Steps * bda_pkg::DIGIT_W;
  localparam int CntW  = $clog2(Steps + 1);

  logic              wr_en;
  logic [DigW-1:0]   wr_dig;
  logic [CntW-1:0]   wr_cnt;
  logic              fifo_full;
  logic              fifo_empty;
  logic              rd_en;
  logic [DigW-1:0]   rd_dig;
  logic [CntW-1:0]   rd_cnt;

  bda_front #(.Steps(Steps)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .value_i     (value_i),
    .wr_en_o     (wr_en),
    .wr_dig_o    (wr_dig),
    .wr_cnt_o    (wr_cnt),
    .fifo_full_i (fifo_full)
  );

  bda_fifo #(.W(DigW + CntW)) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_data_i ({wr_dig, wr_cnt}),
    .full_o    (fifo_full),
    .rd_en_i   (rd_en),
    .rd_data_o ({rd_dig, rd_cnt}),
    .empty_o   (fifo_empty)
  );

  bda_back #(.Steps(Steps)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (fifo_empty),
    .rd_dig_i     (rd_dig),
    .rd_cnt_i     (rd_cnt),
    .rd_en_o      (rd_en),
    .empty        (empty),
    .pop          (pop),
    .digit_char_o (digit_char_o),
    .last_digit_o (last_digit_o)
  );

endmodule

/* rtl/bda_fifo.sv */
// Two-entry queue between the converter and the character emitter.
// Uses no package items.
module bda_fifo #(
  parameter int W = 44
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_en_i,
  input  logic [W-1:0] wr_data_i,
  output logic         full_o,
  input  logic         rd_en_i,
  output logic [W-1:0] rd_data_o,
  output logic         empty_o
);

  logic [1:0][W-1:0] mem_q;
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        cnt_q;

  assign full_o    = (cnt_q == 2'd2);
  assign empty_o   = (cnt_q == 2'd0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (rd_en_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (wr_en_i && !rd_en_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (rd_en_i && !wr_en_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

/* rtl/bda_front.sv */
// Front end: input holding register and iterative divide-by-ten converter.
// Depends on bda_pkg for widths and the reciprocal constants.
module bda_front #(
  parameter int Steps = 10,
  localparam int DigW = Steps * bda_pkg::DIGIT_W,
  localparam int CntW = $clog2(Steps + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic [bda_pkg::VALUE_W-1:0] value_i,
  output logic                       wr_en_o,
  output logic [DigW-1:0]            wr_dig_o,
  output logic [CntW-1:0]            wr_cnt_o,
  input  logic                       fifo_full_i
);

  logic                          hold_vld_q;
  logic [bda_pkg::VALUE_W-1:0]   hold_val_q;
  logic                          busy_q;
  logic [CntW-1:0]               step_q;
  logic [bda_pkg::VALUE_W-1:0]   v_q;
  logic [DigW-1:0]               dig_q;
  logic [CntW-1:0]               cnt_q;

  logic [2*bda_pkg::VALUE_W-1:0] prod;
  logic [bda_pkg::VALUE_W-1:0]   quo;
  logic [bda_pkg::VALUE_W-1:0]   quo_x10;
  logic [bda_pkg::VALUE_W-1:0]   rem_w;
  logic [bda_pkg::DIGIT_W-1:0]   rem;
  logic [DigW-1:0]               dig_d;
  logic [CntW-1:0]               cnt_d;
  logic                          conv_last;
  logic                          advance;
  logic                          take;

  assign prod    = {{bda_pkg::VALUE_W{1'b0}}, v_q}
                 * {{bda_pkg::VALUE_W{1'b0}}, bda_pkg::RECIP_MULT};
  assign quo     = bda_pkg::VALUE_W'(prod >> bda_pkg::RECIP_SHIFT);
  assign quo_x10 = (quo << 3) + (quo << 1);
  assign rem_w   = v_q - quo_x10;
  assign rem     = rem_w[bda_pkg::DIGIT_W-1:0];

  // Shift each new digit in at the top; digit k ends up at position k.
  assign dig_d = (dig_q >> bda_pkg::DIGIT_W)
               | (DigW'(rem) << (DigW - bda_pkg::DIGIT_W));
  assign cnt_d = (rem != '0) ? (step_q + CntW'(1)) : cnt_q;

  assign conv_last = busy_q && (step_q == CntW'(Steps - 1));
  assign advance   = busy_q && !(conv_last && fifo_full_i);
  assign take      = hold_vld_q && (!busy_q || (conv_last && !fifo_full_i));

  assign full     = hold_vld_q;
  assign wr_en_o  = conv_last && !fifo_full_i;
  assign wr_dig_o = dig_d;
  assign wr_cnt_o = cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
      busy_q     <= 1'b0;
      step_q     <= '0;
    end else begin
      if (push && !hold_vld_q) begin
        hold_vld_q <= 1'b1;
      end else if (take) begin
        hold_vld_q <= 1'b0;
      end
      if (take) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (advance) begin
        busy_q <= !conv_last;
        step_q <= step_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && !hold_vld_q) begin
      hold_val_q <= value_i;
    end
    if (take) begin
      v_q   <= hold_val_q;
      dig_q <= '0;
      cnt_q <= CntW'(1);
    end else if (advance) begin
      v_q   <= quo;
      dig_q <= dig_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* rtl/bda_back.sv */
// Back end: emits the digits of one converted number, most significant first.
// Depends on bda_pkg for digit and character widths and the ASCII offset.
module bda_back #(
  parameter int Steps = 10,
  localparam int DigW = Steps * bda_pkg::DIGIT_W,
  localparam int CntW = $clog2(Steps + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fifo_empty_i,
  input  logic [DigW-1:0]             rd_dig_i,
  input  logic [CntW-1:0]             rd_cnt_i,
  output logic                        rd_en_o,
  output logic                        empty,
  input  logic                        pop,
  output logic [bda_pkg::CHAR_W-1:0]  digit_char_o,
  output logic                        last_digit_o
);

  logic                         act_q;
  logic [DigW-1:0]              dig_q;
  logic [CntW-1:0]              idx_q;
  logic                         out_vld_q;
  logic [bda_pkg::CHAR_W-1:0]   out_char_q;
  logic                         out_last_q;

  logic [DigW-1:0]              dig_sh;
  logic [bda_pkg::DIGIT_W-1:0]  cur_dig;
  logic                         at_lsd;
  logic                         adv;
  logic                         load;

  assign dig_sh  = dig_q >> (idx_q * bda_pkg::DIGIT_W);
  assign cur_dig = dig_sh[bda_pkg::DIGIT_W-1:0];
  assign at_lsd  = (idx_q == '0);
  assign adv     = act_q && (!out_vld_q || pop);
  assign load    = !fifo_empty_i && (!act_q || (adv && at_lsd));

  assign rd_en_o      = load;
  assign empty        = !out_vld_q;
  assign digit_char_o = out_char_q;
  assign last_digit_o = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (load) begin
        act_q <= 1'b1;
      end else if (adv && at_lsd) begin
        act_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (pop) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      dig_q <= rd_dig_i;
      idx_q <= rd_cnt_i - CntW'(1);
    end else if (adv) begin
      idx_q <= idx_q - CntW'(1);
    end
    if (adv) begin
      out_char_q <= bda_pkg::ASCII_ZERO + bda_pkg::CHAR_W'(cur_dig);
      out_last_q <= at_lsd;
    end
  end

endmodule

/* rtl/bda_checker.sv */
// Port-level checks of the decimal text converter, bound to the top level.
// Depends on bda_pkg and the assertion macros in the defines header.
`include "binary_to_decimal_ascii_top_defines.svh"

module bda_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        push,
  input logic                        full,
  input logic [bda_pkg::VALUE_W-1:0] value_i,
  input logic                        empty,
  input logic                        pop,
  input logic [bda_pkg::CHAR_W-1:0]  digit_char_o,
  input logic                        last_digit_o
);

  logic [3:0] pend_q;
  logic       start_q;
  logic       in_acc;
  logic       num_done;
  logic       value_seen;

  assign in_acc     = push && !full;
  assign num_done   = pop && !empty && last_digit_o;
  // Touch the payload so every port is read.
  assign value_seen = ^value_i || !(^value_i);

  // Track numbers in flight and whether the next character opens a number.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= '0;
      start_q <= 1'b1;
    end else begin
      if (in_acc && !num_done) begin
        pend_q <= pend_q + 4'd1;
      end else if (num_done && !in_acc) begin
        pend_q <= pend_q - 4'd1;
      end
      if (pop && !empty) begin
        start_q <= last_digit_o;
      end
    end
  end

  `BDA_ASSERT_NEXT(a_hold_stalled, !empty && !pop, !empty && $stable(digit_char_o) && $stable(last_digit_o), "stalled item changed")
  `BDA_ASSERT_NOW(a_char_range, !empty && value_seen, digit_char_o >= 6'd48 && digit_char_o <= 6'd57, "character is not a decimal digit")
  `BDA_ASSERT_NOW(a_no_invented, !empty, pend_q != 4'd0, "item shown with no number pending")
  `BDA_ASSERT_NOW(a_no_lead_zero, !empty && start_q && digit_char_o == 6'd48, last_digit_o, "leading zero emitted")

endmodule

bind binary_to_decimal_ascii_top bda_checker u_bda_checker (.*);
